// ===== rtl/hif_pkg.sv =====
package hif_pkg;

  localparam int FracBits = 16;

  localparam logic [30:0] DryDepthReset = 31'd66;
  localparam logic [30:0] GravityReset  = 31'd642908;

  localparam logic [0:0] RegDryDepth = 1'd0;
  localparam logic [0:0] RegGravity  = 1'd1;

  localparam logic signed [31:0] QMax = 32'sh7fffffff;
  localparam logic signed [31:0] QMin = 32'sh80000000;
  localparam logic signed [31:0] QHalf = 32'sd1 <<< (FracBits - 1);

  typedef struct packed {
    logic signed [31:0] bed_left;
    logic signed [31:0] bed_right;
    logic [30:0]        width_left;
    logic [30:0]        width_right;
    logic [30:0]        depth_left;
    logic [30:0]        depth_right;
    logic signed [31:0] discharge_left;
    logic signed [31:0] discharge_right;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mass_flux;
    logic signed [31:0] momentum_flux;
    logic signed [31:0] source_left;
    logic signed [31:0] source_right;
    logic               zero_spread;
  } out_item_t;

  typedef enum logic [1:0] {
    CaseZero  = 2'd0,
    CaseHll   = 2'd1,
    CaseDryL  = 2'd2,
    CaseDryR  = 2'd3
  } case_e;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'(QMax)) r = QMax;
    else if (v < 34'(QMin)) r = QMin;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat34(34'(a) - 34'(b));
  endfunction

  function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
    return sat34(-34'(a));
  endfunction

  function automatic logic signed [31:0] qmin(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [31:0] qmax(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return (a > b) ? a : b;
  endfunction

  // product rounded to nearest, ties away from zero, saturated
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic [63:0]        m;
    logic [64:0]        r;
    logic signed [65:0] s;
    p = a * b;
    m = p[63] ? (64'd0 - 64'(p)) : 64'(p);
    r = (65'(m) + (65'd1 << (FracBits - 1))) >> FracBits;
    s = p[63] ? -66'(r) : 66'(r);
    if (s > 66'(QMax)) return QMax;
    if (s < 66'(QMin)) return QMin;
    return s[31:0];
  endfunction

endpackage

// ===== rtl/hll_interface_flux_top.sv =====
// Channel  | Handshake               | Payload
// in       | in_valid_i / in_ready_o | in_item_i  (hif_pkg::in_item_t)
// out      | out_valid_o/out_ready_i | out_item_o (hif_pkg::out_item_t)
// cfg      | APB psel/penable/pwrite | paddr[2:0], pwdata/prdata 32 bit
// One interface per cycle unless the pipe is frozen. An accepted input passes
// two entry stages, a 49-stage divider row (the 24-stage square roots run
// beside it), six multiply/add stages, a second 49-stage divider row and the
// output register. The whole pipe advances together and freezes while the
// output register holds an untaken result.
// Reset clears the valid bits and loads the register defaults.
module hll_interface_flux_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hif_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hif_pkg::out_item_t  out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import hif_pkg::*;

  localparam int DivLat  = 32 + FracBits + 1;
  localparam int SqrtLat = (32 + FracBits + 1) / 2;

  // ---------------- configuration
  logic [30:0] hmin_q, grav_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hmin_q <= DryDepthReset;
      grav_q <= GravityReset;
    end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0) begin
      if (paddr[2:2] == RegDryDepth) hmin_q <= pwdata[30:0];
      else if (paddr[2:2] == RegGravity) grav_q <= pwdata[30:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      if (paddr[2:2] == RegDryDepth) prdata = {1'b0, hmin_q};
      else prdata = {1'b0, grav_q};
    end
  end

  // ---------------- global stall
  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // valid shift line over all stages
  localparam int Depth = 2 + DivLat + 6 + DivLat + 1;
  logic [Depth-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], in_valid_i};
  end

  // ---------------- stage A1: case selection, mul g*h
  logic signed [31:0] g, hmin;
  assign g = {1'b0, grav_q};
  assign hmin = {1'b0, hmin_q};

  typedef struct packed {
    logic signed [31:0] zbl, zbr, phl, phr, hl, hr, ql, qr;
    logic signed [31:0] hml, hmr;
    case_e              cs;
  } ctx_t;

  ctx_t a1_q;
  logic signed [31:0] ghl_q, ghr_q;
  always_ff @(posedge clk_i) begin
    logic signed [31:0] hl, hr, zbl, zbr;
    logic signed [33:0] levl, levr;
    hl = {1'b0, in_item_i.depth_left};
    hr = {1'b0, in_item_i.depth_right};
    zbl = in_item_i.bed_left;
    zbr = in_item_i.bed_right;
    levl = 34'(hl) + 34'(zbl);
    levr = 34'(hr) + 34'(zbr);
    if (en) begin
      a1_q.zbl <= zbl; a1_q.zbr <= zbr;
      a1_q.phl <= {1'b0, in_item_i.width_left};
      a1_q.phr <= {1'b0, in_item_i.width_right};
      a1_q.hl <= hl; a1_q.hr <= hr;
      a1_q.ql <= in_item_i.discharge_left;
      a1_q.qr <= in_item_i.discharge_right;
      a1_q.hml <= qmax(hmin, hl);
      a1_q.hmr <= qmax(hmin, hr);
      if ((hl > hmin && hr > hmin) || (hl <= hmin && levr >= 34'(zbl)) ||
          (hr <= hmin && levl >= 34'(zbr))) a1_q.cs <= CaseHll;
      else if (hl < hmin && levr < 34'(zbl)) a1_q.cs <= CaseDryL;
      else if (hr < hmin && levl < 34'(zbr)) a1_q.cs <= CaseDryR;
      else a1_q.cs <= CaseZero;
      ghl_q <= qmul(g, hl);
      ghr_q <= qmul(g, hr);
    end
  end

  // ---------------- sqrt row, plus velocity dividers and q^2/h alongside
  logic signed [31:0] cl, cr;
  hif_sqrt u_sql (.clk_i, .en_i(en), .x_i(ghl_q), .r_o(cl));
  hif_sqrt u_sqr (.clk_i, .en_i(en), .x_i(ghr_q), .r_o(cr));

  // products independent of wave speeds, computed in stage A2
  logic signed [31:0] qql_q, qqr_q, hhl_q, hhr_q, hg_q, phlr_q;
  ctx_t a2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q   <= a1_q;
      qql_q  <= qmul(a1_q.ql, a1_q.ql);
      qqr_q  <= qmul(a1_q.qr, a1_q.qr);
      hhl_q  <= qmul(a1_q.hl, a1_q.hl);
      hhr_q  <= qmul(a1_q.hr, a1_q.hr);
      hg_q   <= qmul(QHalf, g);
      phlr_q <= qmin(a1_q.phl, a1_q.phr);
    end
  end

  // velocity and q^2/h dividers: fed from the A2 registers
  logic signed [31:0] ul, ur, pdl, pdr;
  hif_div u_dul (.clk_i, .en_i(en), .a_i(a2_q.ql), .b_i(a2_q.hml), .q_o(ul));
  hif_div u_dur (.clk_i, .en_i(en), .a_i(a2_q.qr), .b_i(a2_q.hmr), .q_o(ur));
  hif_div u_dpl (.clk_i, .en_i(en), .a_i(qql_q), .b_i(a2_q.hml), .q_o(pdl));
  hif_div u_dpr (.clk_i, .en_i(en), .a_i(qqr_q), .b_i(a2_q.hmr), .q_o(pdr));

  // delay sqrt results to align them with the divider results
  localparam int SqDly = 1 + DivLat - SqrtLat;
  logic signed [31:0] cl_d [SqDly];
  logic signed [31:0] cr_d [SqDly];
  always_ff @(posedge clk_i) begin
    if (en) begin
      cl_d[0] <= cl; cr_d[0] <= cr;
      for (int k = 1; k < SqDly; k++) begin
        cl_d[k] <= cl_d[k-1];
        cr_d[k] <= cr_d[k-1];
      end
    end
  end

  // context delay line from A2 over DivLat stages
  typedef struct packed {
    ctx_t               c;
    logic signed [31:0] hhl, hhr, hg, phlr;
  } ctx2_t;
  ctx2_t cx_d [DivLat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_d[0] <= '{c: a2_q, hhl: hhl_q, hhr: hhr_q, hg: hg_q, phlr: phlr_q};
      for (int k = 1; k < DivLat; k++) cx_d[k] <= cx_d[k-1];
    end
  end
  ctx2_t b0;
  assign b0 = cx_d[DivLat-1];
  logic signed [31:0] clb, crb;
  assign clb = cl_d[SqDly-1];
  assign crb = cr_d[SqDly-1];

  // ---------------- B1: wave speeds, levels, p terms
  typedef struct packed {
    case_e              cs;
    logic signed [31:0] ql, qr, phl, phr, hl, hr, hhl, hhr, hg, phlr;
    logic signed [31:0] l1, l2, zl, zr, pdl, pdr;
  } b_t;
  b_t b1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q.cs <= b0.c.cs;
      b1_q.ql <= b0.c.ql; b1_q.qr <= b0.c.qr;
      b1_q.phl <= b0.c.phl; b1_q.phr <= b0.c.phr;
      b1_q.hl <= b0.c.hl; b1_q.hr <= b0.c.hr;
      b1_q.hhl <= b0.hhl; b1_q.hhr <= b0.hhr;
      b1_q.hg <= b0.hg; b1_q.phlr <= b0.phlr;
      b1_q.l1 <= qmin(32'sd0, qmin(qsub(ul, clb), qsub(ur, crb)));
      b1_q.l2 <= qmax(32'sd0, qmax(qadd(ul, clb), qadd(ur, crb)));
      b1_q.zl <= qadd(b0.c.hl, b0.c.zbl);
      b1_q.zr <= qadd(b0.c.hr, b0.c.zbr);
      b1_q.pdl <= pdl; b1_q.pdr <= pdr;
    end
  end

  // ---------------- B2: first products
  typedef struct packed {
    case_e              cs;
    logic signed [31:0] ql, qr, phl, phr, hl, hr, hg, phlr, l1, l2, zl, zr;
    logic signed [31:0] spread, l12, l2ql, l1qr, dz, pl, pr, l2phl, l1phr;
    logic signed [31:0] phrqr, phlql, al, ar, hwl, hlr, gl1, gl2;
    logic signed [31:0] hhl, hhr;
  } c_t;
  c_t b2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_q.cs <= b1_q.cs;
      b2_q.ql <= b1_q.ql; b2_q.qr <= b1_q.qr;
      b2_q.phl <= b1_q.phl; b2_q.phr <= b1_q.phr;
      b2_q.hl <= b1_q.hl; b2_q.hr <= b1_q.hr;
      b2_q.hg <= b1_q.hg; b2_q.phlr <= b1_q.phlr;
      b2_q.l1 <= b1_q.l1; b2_q.l2 <= b1_q.l2;
      b2_q.zl <= b1_q.zl; b2_q.zr <= b1_q.zr;
      b2_q.hhl <= b1_q.hhl; b2_q.hhr <= b1_q.hhr;
      b2_q.spread <= qsub(b1_q.l2, b1_q.l1);
      b2_q.l12 <= qmul(b1_q.l1, b1_q.l2);
      b2_q.l2ql <= qmul(b1_q.l2, b1_q.ql);
      b2_q.l1qr <= qmul(b1_q.l1, b1_q.qr);
      b2_q.dz <= qsub(b1_q.zr, b1_q.zl);
      b2_q.pl <= qmul(b1_q.hg, b1_q.hhl);
      b2_q.pr <= qmul(b1_q.hg, b1_q.hhr);
      b2_q.l2phl <= qmul(b1_q.l2, b1_q.phl);
      b2_q.l1phr <= qmul(b1_q.l1, b1_q.phr);
      b2_q.phrqr <= qmul(b1_q.phr, b1_q.qr);
      b2_q.phlql <= qmul(b1_q.phl, b1_q.ql);
      b2_q.al <= qmul(b1_q.phl, b1_q.hhl);
      b2_q.ar <= qmul(b1_q.phr, b1_q.hhr);
      b2_q.hwl <= qmul(QHalf, b1_q.phlr);
      b2_q.hlr <= qadd(b1_q.hl, b1_q.hr);
      b2_q.gl1 <= qmul(g, b1_q.l1);
      b2_q.gl2 <= qmul(g, b1_q.l2);
    end
    // pl/pr finish in B3 with the q^2/h terms
  end
  logic signed [31:0] pdl2_q, pdr2_q;
  always_ff @(posedge clk_i) if (en) begin pdl2_q <= b1_q.pdl; pdr2_q <= b1_q.pdr; end

  // ---------------- B3
  typedef struct packed {
    case_e              cs;
    logic signed [31:0] spread, l12, phlr, n1a, dz, pl, pr, l2phl, l1phr, dphq;
    logic signed [31:0] al, ar, wsum, zl, zr, gl1, gl2, hg, phl, phr, hhl, hhr;
  } d_t;
  d_t b3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b3_q.cs <= b2_q.cs;
      b3_q.spread <= b2_q.spread; b3_q.l12 <= b2_q.l12; b3_q.phlr <= b2_q.phlr;
      b3_q.n1a <= qsub(b2_q.l2ql, b2_q.l1qr);
      b3_q.dz <= b2_q.dz;
      b3_q.pl <= qadd(pdl2_q, b2_q.pl);
      b3_q.pr <= qadd(pdr2_q, b2_q.pr);
      b3_q.l2phl <= b2_q.l2phl; b3_q.l1phr <= b2_q.l1phr;
      b3_q.dphq <= qsub(b2_q.phrqr, b2_q.phlql);
      b3_q.al <= b2_q.al; b3_q.ar <= b2_q.ar;
      b3_q.wsum <= qmul(b2_q.hwl, b2_q.hlr);
      b3_q.zl <= b2_q.zl; b3_q.zr <= b2_q.zr;
      b3_q.gl1 <= b2_q.gl1; b3_q.gl2 <= b2_q.gl2;
      b3_q.hg <= b2_q.hg; b3_q.phl <= b2_q.phl; b3_q.phr <= b2_q.phr;
      b3_q.hhl <= b2_q.hhl; b3_q.hhr <= b2_q.hhr;
    end
  end

  // ---------------- B4
  typedef struct packed {
    case_e              cs;
    logic signed [31:0] spread, phlr, n1a, n1b, t2l, t2r, t2c, hdl, hdr, wdl, wdr;
    logic signed [31:0] gl1, gl2, dryl, dryr, hhl, hhr;
  } e_t;
  e_t b4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b4_q.cs <= b3_q.cs; b4_q.spread <= b3_q.spread; b4_q.phlr <= b3_q.phlr;
      b4_q.n1a <= b3_q.n1a;
      b4_q.n1b <= qmul(b3_q.l12, b3_q.dz);
      b4_q.t2l <= qmul(b3_q.l2phl, b3_q.pl);
      b4_q.t2r <= qmul(b3_q.l1phr, b3_q.pr);
      b4_q.t2c <= qmul(b3_q.l12, b3_q.dphq);
      b4_q.hdl <= qmul(QHalf, qsub(b3_q.al, b3_q.ar));
      b4_q.hdr <= qmul(QHalf, qsub(b3_q.ar, b3_q.al));
      b4_q.wdl <= qmul(b3_q.wsum, qsub(b3_q.zl, b3_q.zr));
      b4_q.wdr <= qmul(b3_q.wsum, qsub(b3_q.zr, b3_q.zl));
      b4_q.gl1 <= b3_q.gl1; b4_q.gl2 <= b3_q.gl2;
      b4_q.dryl <= qmul(b3_q.hg, b3_q.phl);
      b4_q.dryr <= qmul(b3_q.hg, b3_q.phr);
      b4_q.hhl <= b3_q.hhl; b4_q.hhr <= b3_q.hhr;
    end
  end

  // ---------------- B5
  typedef struct packed {
    case_e              cs;
    logic signed [31:0] spread, phlr, n1, n2, il, ir, gl1, gl2, dryl, dryr;
  } f_t;
  f_t b5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b5_q.cs <= b4_q.cs; b5_q.spread <= b4_q.spread; b5_q.phlr <= b4_q.phlr;
      b5_q.n1 <= qadd(b4_q.n1a, b4_q.n1b);
      b5_q.n2 <= qadd(qsub(b4_q.t2l, b4_q.t2r), b4_q.t2c);
      b5_q.il <= qsub(b4_q.hdl, b4_q.wdl);
      b5_q.ir <= qsub(b4_q.hdr, b4_q.wdr);
      b5_q.gl1 <= b4_q.gl1; b5_q.gl2 <= b4_q.gl2;
      b5_q.dryl <= qmul(b4_q.dryl, b4_q.hhl);
      b5_q.dryr <= qmul(b4_q.dryr, b4_q.hhr);
    end
  end

  // ---------------- B6: numerators
  typedef struct packed {
    case_e              cs;
    logic               zs;
    logic signed [31:0] spread, nf1, nf2, nsl, nsr, dryl, dryr;
  } h_t;
  h_t b6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b6_q.cs <= b5_q.cs;
      b6_q.zs <= (b5_q.spread == 32'sd0);
      b6_q.spread <= b5_q.spread;
      b6_q.nf1 <= qmul(b5_q.phlr, b5_q.n1);
      b6_q.nf2 <= b5_q.n2;
      b6_q.nsl <= qmul(b5_q.gl1, b5_q.il);
      b6_q.nsr <= qmul(b5_q.gl2, b5_q.ir);
      b6_q.dryl <= qneg(b5_q.dryl);
      b6_q.dryr <= b5_q.dryr;
    end
  end

  logic signed [31:0] f1, f2, sl, sr;
  hif_div u_df1 (.clk_i, .en_i(en), .a_i(b6_q.nf1), .b_i(b6_q.spread), .q_o(f1));
  hif_div u_df2 (.clk_i, .en_i(en), .a_i(b6_q.nf2), .b_i(b6_q.spread), .q_o(f2));
  hif_div u_dsl (.clk_i, .en_i(en), .a_i(b6_q.nsl), .b_i(b6_q.spread), .q_o(sl));
  hif_div u_dsr (.clk_i, .en_i(en), .a_i(b6_q.nsr), .b_i(b6_q.spread), .q_o(sr));

  typedef struct packed {
    case_e              cs;
    logic               zs;
    logic signed [31:0] dryl, dryr;
  } k_t;
  k_t kd [DivLat];
  always_ff @(posedge clk_i) begin
    if (en) begin
      kd[0] <= '{cs: b6_q.cs, zs: b6_q.zs, dryl: b6_q.dryl, dryr: b6_q.dryr};
      for (int k = 1; k < DivLat; k++) kd[k] <= kd[k-1];
    end
  end

  // ---------------- output register
  k_t kf;
  assign kf = kd[DivLat-1];
  always_ff @(posedge clk_i) begin
    out_item_t res;
    res = '0;
    case (kf.cs)
      CaseHll: begin
        if (kf.zs) res.zero_spread = 1'b1;
        else begin
          res.mass_flux = f1;
          res.momentum_flux = f2;
          res.source_left = sl;
          res.source_right = sr;
        end
      end
      CaseDryL: res.source_right = kf.dryr;
      CaseDryR: res.source_left = kf.dryl;
      default: ;
    endcase
    if (en) out_item_o <= res;
  end
  assign out_valid_o = vld_q[Depth-1];

endmodule

// ===== rtl/hif_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
// q = round(|a|*2^F / |b|), signed, saturated; b == 0 gives zero.
module hif_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] q_o
);
  import hif_pkg::*;

  localparam int NBits = 32 + FracBits + 1; // quotient bits incl. one rounding bit
  localparam int DW = 33;

  logic [NBits-1:0] num_q [NBits+1];
  logic [DW-1:0]    den_q [NBits+1];
  logic [DW:0]      rem_q [NBits+1];
  logic [NBits-1:0] quo_q [NBits+1];
  logic             neg_q [NBits+1];
  logic             zer_q [NBits+1];

  always_comb begin
    num_q[0] = NBits'(a_i[31] ? (33'd0 - 33'(a_i)) : 33'(a_i)) << (FracBits + 1);
    den_q[0] = b_i[31] ? (33'd0 - 33'(b_i)) : 33'(b_i);
    rem_q[0] = '0;
    quo_q[0] = '0;
    neg_q[0] = a_i[31] ^ b_i[31];
    zer_q[0] = (b_i == 32'sd0);
  end

  for (genvar k = 0; k < NBits; k++) begin : g_stage
    logic [DW:0] tr;
    logic [DW:0] df;
    assign tr = {rem_q[k][DW-1:0], num_q[k][NBits-1]};
    assign df = tr - (DW+1)'(den_q[k]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1] <= num_q[k] << 1;
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        zer_q[k+1] <= zer_q[k];
        if (!df[DW]) begin
          rem_q[k+1] <= df;
          quo_q[k+1] <= {quo_q[k][NBits-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= tr;
          quo_q[k+1] <= {quo_q[k][NBits-2:0], 1'b0};
        end
      end
    end
  end

  // quotient holds 2*n/d; rounding: (2x+1)>>1 equals floor((n + d/2)/d) for integers
  logic [NBits:0]     rnd;
  logic signed [NBits+1:0] sv;
  always_comb begin
    rnd = ((NBits+1)'(quo_q[NBits]) + (NBits+1)'(1)) >> 1;
    sv  = neg_q[NBits] ? -(NBits+2)'(rnd) : (NBits+2)'(rnd);
    if (zer_q[NBits]) q_o = '0;
    else if (sv > (NBits+2)'(QMax)) q_o = QMax;
    else if (sv < (NBits+2)'(QMin)) q_o = QMin;
    else q_o = sv[31:0];
  end
endmodule

// ===== rtl/hif_sqrt.sv =====
// Pipelined integer square root of x*2^F, one result bit per stage.
module hif_sqrt (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] x_i,
  output logic signed [31:0] r_o
);
  import hif_pkg::*;

  localparam int VW = 32 + FracBits;
  localparam int NS = (VW + 1) / 2;

  logic [VW-1:0]   v_q [NS+1];
  logic [NS+1:0]   rem_q [NS+1];
  logic [NS-1:0]   res_q [NS+1];

  always_comb begin
    v_q[0]   = (x_i <= 32'sd0) ? '0 : (VW'(x_i) << FracBits);
    rem_q[0] = '0;
    res_q[0] = '0;
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [NS+1:0] tr;
    logic [NS+1:0] tt;
    assign tr = {rem_q[k][NS-1:0], v_q[k][VW-1 -: 2]};
    assign tt = {res_q[k], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k+1] <= v_q[k] << 2;
        if (tr >= tt) begin
          rem_q[k+1] <= tr - tt;
          res_q[k+1] <= {res_q[k][NS-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= tr;
          res_q[k+1] <= {res_q[k][NS-2:0], 1'b0};
        end
      end
    end
  end

  assign r_o = 32'(res_q[NS]);
endmodule

// ===== rtl/hif_checker.sv =====
module hif_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input hif_pkg::out_item_t out_item_o,
  input logic               pready
);
  import hif_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed under stall");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output side");

  a_zs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.zero_spread |->
      out_item_o.mass_flux == 32'sd0 && out_item_o.momentum_flux == 32'sd0 &&
      out_item_o.source_left == 32'sd0 && out_item_o.source_right == 32'sd0)
    else $error("zero spread with nonzero outputs");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
endmodule

bind hll_interface_flux_top hif_checker u_hif_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .out_item_o, .pready
);
